// File: rtl/overscan_border_compositor_macros.svh
// ----------------------------------------------------------------------------
// Overscan border compositor assertion macros
// Shared concurrent assertion wrappers, clocked and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef OVERSCAN_BORDER_COMPOSITOR_MACROS_SVH
`define OVERSCAN_BORDER_COMPOSITOR_MACROS_SVH

// Same-cycle implication.
`define OBC_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("obc assertion failed");

// Next-cycle implication.
`define OBC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("obc assertion failed");

`endif

// File: rtl/obc_pkg.sv
// ----------------------------------------------------------------------------
// obc_pkg
// Types, constants and color expansion shared by the border compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package obc_pkg;

   // Geometry defaults
   localparam int MAX_LINES_DEF   = 224;
   localparam int BORDER_COLS_DEF = 32;
   localparam int BORDER_ROWS_DEF = 16;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int WIDTH_W = 10;
   localparam int CSR_W   = 10;
   localparam int IDX_W   = 3;

   // Magic bytes of the gated block: 'O', 'C'
   localparam logic [BYTE_W-1:0] MAGIC_FIRST  = 8'h4F;
   localparam logic [BYTE_W-1:0] MAGIC_SECOND = 8'h43;

   // Item modes
   localparam logic MODE_LATCH   = 1'b0;
   localparam logic MODE_COMPOSE = 1'b1;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_PROFILE  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_UNLOCKED = 3'd1;
   localparam logic [IDX_W-1:0] CSR_REGS     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_WIDTH    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_HEIGHT   = 3'd4;

   // Register reset values
   localparam logic [WIDTH_W-1:0] WIDTH_RST  = 10'd240;
   localparam logic [BYTE_W-1:0]  HEIGHT_RST = 8'd224;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_type;

   localparam rgb_type BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

   // 3-bit channel to 8 bits: v*255/7
   function automatic logic [BYTE_W-1:0] lut3(input logic [2:0] v);
      logic [BYTE_W-1:0] r;
      case (v)
         3'd0:    r = 8'd0;
         3'd1:    r = 8'd36;
         3'd2:    r = 8'd72;
         3'd3:    r = 8'd109;
         3'd4:    r = 8'd145;
         3'd5:    r = 8'd182;
         3'd6:    r = 8'd218;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

   // 2-bit channel to 8 bits: v*255/3
   function automatic logic [BYTE_W-1:0] lut2(input logic [1:0] v);
      logic [BYTE_W-1:0] r;
      case (v)
         2'd0:    r = 8'd0;
         2'd1:    r = 8'd85;
         2'd2:    r = 8'd170;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

   // RGB332 RRRGGGBB to RGB888
   function automatic rgb_type expand332(input logic [BYTE_W-1:0] v);
      rgb_type c;
      c.red   = lut3(v[7:5]);
      c.green = lut3(v[4:2]);
      c.blue  = lut2(v[1:0]);
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/obc_line_store.sv
// ----------------------------------------------------------------------------
// obc_line_store
// Per-line border color memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module obc_line_store #(
   parameter int DEPTH  = obc_pkg::MAX_LINES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire obc_pkg::rgb_type  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output obc_pkg::rgb_type       rd_data,
   output logic                   busy
);

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

   obc_pkg::rgb_type mem [DEPTH];
   obc_pkg::rgb_type rd_data_ff;
   logic              clr_ff;
   logic              clr_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] clr_cnt_in;

   // Clear sequencer: one entry per cycle
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Write port: clearing pass or latched colors
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= obc_pkg::BLACK;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

`default_nettype wire

// File: rtl/overscan_border_compositor.sv
// ----------------------------------------------------------------------------
// overscan_border_compositor
// Latches per-line border colors and composes bordered output pixels.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and passes each compose
// item through decode, clamp/expand, line memory read and output register
// stages. A latch item writes the line memory in the third stage and gives no
// result; any compose item accepted after it sees the new color. After reset
// the line memory is cleared to black, one line per clock, with req_stall high
// until it is done; configuration writes are taken during that time.
// rsp_stall stops the whole pipeline without losing or repeating items.
`default_nettype none

`include "overscan_border_compositor_macros.svh"

module overscan_border_compositor #(
   parameter int MAX_LINES   = obc_pkg::MAX_LINES_DEF,
   parameter int BORDER_COLS = obc_pkg::BORDER_COLS_DEF,
   parameter int BORDER_ROWS = obc_pkg::BORDER_ROWS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [obc_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [obc_pkg::CSR_W-1:0]   csr_wdata,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_mode,
   input  wire logic [7:0]                  req_latch_line,
   input  wire logic [7:0]                  req_reg_border,
   input  wire logic [7:0]                  req_mem_border,
   input  wire logic [7:0]                  req_magic_first,
   input  wire logic [7:0]                  req_magic_second,
   input  wire logic                        req_regs_armed,
   input  wire logic [9:0]                  req_out_x,
   input  wire logic [7:0]                  req_out_y,
   input  wire logic [7:0]                  req_pix_red,
   input  wire logic [7:0]                  req_pix_green,
   input  wire logic [7:0]                  req_pix_blue,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic                             rsp_from_active
);

   localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CMP_W  = 11;
   localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic       profile_ff;
   logic       unlocked_ff;
   logic       regs_wired_ff;
   logic [9:0] width_ff;
   logic [7:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff    <= 1'b0;
         unlocked_ff   <= 1'b0;
         regs_wired_ff <= 1'b0;
         width_ff      <= obc_pkg::WIDTH_RST;
         height_ff     <= obc_pkg::HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            obc_pkg::CSR_PROFILE:  profile_ff    <= csr_wdata[0];
            obc_pkg::CSR_UNLOCKED: unlocked_ff   <= csr_wdata[0];
            obc_pkg::CSR_REGS:     regs_wired_ff <= csr_wdata[0];
            obc_pkg::CSR_WIDTH:    width_ff      <= csr_wdata[9:0];
            obc_pkg::CSR_HEIGHT:   height_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its item moves on
   // ------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, rsp_v_in;
   logic en_out, en3, en2, en1;
   logic store_busy;
   logic req_acc;

   assign en_out    = !rsp_v_ff || !rsp_stall;
   assign en3       = !s3_v_ff || en_out;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = !en1 || store_busy;
   assign req_acc   = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Stage 1: source select and area compare
   // ------------------------------------------------------------------
   logic             s1_mode_ff;
   logic             s1_line_ok_ff;
   logic [LINE_W-1:0] s1_line_ff;
   logic [7:0]       s1_byte_ff;
   logic             s1_black_ff;
   logic             s1_active_ff;
   logic             s1_top_ff;
   logic             s1_below_ff;
   logic [7:0]       s1_ay_ff;
   obc_pkg::rgb_type s1_pix_ff;

   logic             regs_on, block_on;
   logic             s1_line_ok_in, s1_black_in, s1_active_in;
   logic             s1_top_in, s1_below_in;
   logic [7:0]       s1_byte_in;
   logic [CMP_W-1:0] ay_raw, ax_raw;
   logic             y_neg, x_neg, in_rows, in_cols;

   always_comb begin
      regs_on  = profile_ff && regs_wired_ff && req_regs_armed;
      block_on = profile_ff && unlocked_ff &&
                 (req_magic_first == obc_pkg::MAGIC_FIRST) &&
                 (req_magic_second == obc_pkg::MAGIC_SECOND);
      s1_byte_in    = regs_on ? req_reg_border : req_mem_border;
      s1_black_in   = !regs_on && !block_on;
      s1_line_ok_in = CMP_W'(req_latch_line) < CMP_W'(MAX_LINES);

      y_neg   = CMP_W'(req_out_y) < CMP_W'(BORDER_ROWS);
      ay_raw  = CMP_W'(req_out_y) - CMP_W'(BORDER_ROWS);
      x_neg   = CMP_W'(req_out_x) < CMP_W'(BORDER_COLS);
      ax_raw  = CMP_W'(req_out_x) - CMP_W'(BORDER_COLS);
      in_rows = !y_neg && (ay_raw < CMP_W'(height_ff));
      in_cols = !x_neg && (ax_raw < CMP_W'(width_ff));

      s1_active_in = in_rows && in_cols;
      s1_top_in    = y_neg || (height_ff == '0);
      s1_below_in  = !y_neg && !in_rows;
   end

   assign s1_v_in = en1 ? req_acc : s1_v_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff      <= req_mode;
         s1_line_ok_ff   <= s1_line_ok_in;
         s1_line_ff      <= LINE_W'(req_latch_line);
         s1_byte_ff      <= s1_byte_in;
         s1_black_ff     <= s1_black_in;
         s1_active_ff    <= s1_active_in;
         s1_top_ff       <= s1_top_in;
         s1_below_ff     <= s1_below_in;
         s1_ay_ff        <= ay_raw[7:0];
         s1_pix_ff.red   <= req_pix_red;
         s1_pix_ff.green <= req_pix_green;
         s1_pix_ff.blue  <= req_pix_blue;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: color expansion and row clamp
   // ------------------------------------------------------------------
   logic             s2_mode_ff;
   logic             s2_wr_ff;
   logic [LINE_W-1:0] s2_addr_ff;
   obc_pkg::rgb_type s2_color_ff;
   logic             s2_active_ff;
   obc_pkg::rgb_type s2_pix_ff;

   logic [7:0]        cy;
   logic              cy_sat;
   logic [LINE_W-1:0] s2_addr_in;
   obc_pkg::rgb_type  s2_color_in;

   always_comb begin
      if (s1_top_ff) begin
         cy = '0;
      end else if (s1_below_ff) begin
         cy = height_ff - 8'd1;
      end else begin
         cy = s1_ay_ff;
      end
      cy_sat = CMP_W'(cy) >= CMP_W'(MAX_LINES);

      if (s1_mode_ff == obc_pkg::MODE_LATCH) begin
         s2_addr_in = s1_line_ff;
      end else if (cy_sat) begin
         s2_addr_in = LINE_LAST;
      end else begin
         s2_addr_in = LINE_W'(cy);
      end

      s2_color_in = s1_black_ff ? obc_pkg::BLACK : obc_pkg::expand332(s1_byte_ff);
   end

   assign s2_v_in = en2 ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_mode_ff   <= s1_mode_ff;
         s2_wr_ff     <= (s1_mode_ff == obc_pkg::MODE_LATCH) && s1_line_ok_ff;
         s2_addr_ff   <= s2_addr_in;
         s2_color_ff  <= s2_color_in;
         s2_active_ff <= s1_active_ff;
         s2_pix_ff    <= s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: line memory write or read
   // ------------------------------------------------------------------
   logic             mem_wr_en;
   logic             mem_rd_en;
   obc_pkg::rgb_type border_rd;
   logic             s3_active_ff;
   obc_pkg::rgb_type s3_pix_ff;

   assign mem_wr_en = en3 && s2_v_ff && s2_wr_ff;
   assign mem_rd_en = en3;

   obc_line_store #(
      .DEPTH  (MAX_LINES),
      .ADDR_W (LINE_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_color_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (s2_addr_ff),
      .rd_data (border_rd),
      .busy    (store_busy)
   );

   // Latch items leave the pipe here
   assign s3_v_in = en3 ? (s2_v_ff && (s2_mode_ff == obc_pkg::MODE_COMPOSE)) : s3_v_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_active_ff <= s2_active_ff;
         s3_pix_ff    <= s2_pix_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: output register
   // ------------------------------------------------------------------
   obc_pkg::rgb_type rsp_color_ff;
   obc_pkg::rgb_type rsp_color_in;
   logic             rsp_active_ff;

   assign rsp_color_in = s3_active_ff ? s3_pix_ff : border_rd;
   assign rsp_v_in     = en_out ? s3_v_ff : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_color_ff  <= rsp_color_in;
         rsp_active_ff <= s3_active_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_red         = rsp_color_ff.red;
   assign rsp_green       = rsp_color_ff.green;
   assign rsp_blue        = rsp_color_ff.blue;
   assign rsp_from_active = rsp_active_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `OBC_ASSERT_NEXT(a_no_entry_while_clearing, clock, reset, store_busy, !s1_v_ff)
   `OBC_ASSERT_NEXT(a_latch_drops_out, clock, reset,
                    s2_v_ff && (s2_mode_ff == obc_pkg::MODE_LATCH) && en3, !s3_v_ff)
   `OBC_ASSERT_NEXT(a_accept_enters, clock, reset, req_acc, s1_v_ff)
   `OBC_ASSERT_NOW(a_no_write_on_compose, clock, reset,
                   mem_wr_en, s2_mode_ff == obc_pkg::MODE_LATCH)

endmodule

`default_nettype wire
